[rtl/core/fwsrc_pkg.sv]
// ----------------------------------------------------------------------------
// fwsrc_pkg: shared types and constants of the four-way search result cache
// Entry and bucket layouts, item and result records, op codes, score limits.
// ----------------------------------------------------------------------------
package fwsrc_pkg;

	localparam int WAYS  = 4;
	localparam int WAY_W = 2;

	localparam int KEY_W   = 64;
	localparam int MOVE_W  = 32;
	localparam int SCORE_W = 16;
	localparam int DEPTH_W = 8;
	localparam int BOUND_W = 2;
	localparam int AGE_W   = 8;
	localparam int PLY_W   = 8;
	localparam int OP_W    = 2;
	localparam int MODE_W  = 2;

	localparam int S_TDATA_W = 168;
	localparam int M_TDATA_W = 72;

	// mate window and score clamp
	localparam int MATE_LIMIT = 31000;
	localparam int SCORE_MAX  = 32767;

	localparam logic [OP_W-1:0] OP_PROBE      = 2'd0;
	localparam logic [OP_W-1:0] OP_STORE      = 2'd1;
	localparam logic [OP_W-1:0] OP_NEW_SEARCH = 2'd2;

	typedef struct packed {
		logic [KEY_W-1:0]          key;
		logic [MOVE_W-1:0]         move;
		logic signed [SCORE_W-1:0] score;
		logic [DEPTH_W-1:0]        depth;
		logic [BOUND_W-1:0]        bound;
		logic [AGE_W-1:0]          age;
	} entry_t;

	typedef entry_t [WAYS-1:0] bucket_t;

	typedef struct packed {
		logic [OP_W-1:0]           op;
		logic [KEY_W-1:0]          position_key;
		logic [DEPTH_W-1:0]        search_depth;
		logic signed [SCORE_W-1:0] alpha_bound;
		logic signed [SCORE_W-1:0] beta_bound;
		logic [PLY_W-1:0]          ply_distance;
		logic [MOVE_W-1:0]         move_word;
		logic signed [SCORE_W-1:0] store_score;
		logic [BOUND_W-1:0]        bound_kind;
	} item_t;

	typedef struct packed {
		logic                      hit;
		logic                      cutoff;
		logic [MOVE_W-1:0]         hit_move;
		logic signed [SCORE_W-1:0] hit_score;
		logic [DEPTH_W-1:0]        hit_depth;
		logic [BOUND_W-1:0]        hit_bound;
		logic [AGE_W-1:0]          hit_age;
	} result_t;

	// write-back request from the way logic
	typedef struct packed {
		logic    wr_en;
		bucket_t row;
	} update_t;

endpackage

[rtl/core/fwsrc_bucket_ram.sv]
// ----------------------------------------------------------------------------
// fwsrc_bucket_ram: bucket storage
// One row per bucket holding all four ways; one write port, one read port
// with registered read data.
// ----------------------------------------------------------------------------
module fwsrc_bucket_ram #(
	parameter int  BUCKETS = 1024,
	localparam int IDX_W   = $clog2(BUCKETS)
) (
	input  logic                clk,
	input  logic                wr_en,
	input  logic [IDX_W-1:0]    wr_addr,
	input  fwsrc_pkg::bucket_t  wr_data,
	input  logic                rd_en,
	input  logic [IDX_W-1:0]    rd_addr,
	output fwsrc_pkg::bucket_t  rd_data
);
	import fwsrc_pkg::*;

	bucket_t mem [BUCKETS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[rtl/core/fwsrc_bucket_index.sv]
// ----------------------------------------------------------------------------
// fwsrc_bucket_index: key to bucket number
// Power-of-two bucket count: low key bits, same cycle. Otherwise a
// restoring remainder over the key, eight bits a cycle.
// ----------------------------------------------------------------------------
module fwsrc_bucket_index #(
	parameter int  BUCKETS = 1024,
	localparam int IDX_W   = $clog2(BUCKETS)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [fwsrc_pkg::KEY_W-1:0]   key,
	output logic                          done,
	output logic [IDX_W-1:0]              index
);
	import fwsrc_pkg::*;

	localparam bit IS_POW2 = (BUCKETS & (BUCKETS - 1)) == 0;

	if (IS_POW2) begin : g_mask
		assign done  = start;
		assign index = key[IDX_W-1:0];
	end else begin : g_rem
		localparam int            STEP_BITS = 8;
		localparam int            STEPS     = KEY_W / STEP_BITS;
		localparam logic [IDX_W:0] B_V      = (IDX_W + 1)'(BUCKETS);

		logic [KEY_W-1:0] key_sh_q;
		logic [IDX_W-1:0] rem_q;
		logic [IDX_W-1:0] rem_next;
		logic [2:0]       cnt_q;
		logic             busy_q;
		logic             done_q;

		// remainder stays below BUCKETS, so one compare-subtract per bit
		always_comb begin
			logic [IDX_W:0] t;
			rem_next = rem_q;
			for (int i = 0; i < STEP_BITS; i++) begin
				t = {rem_next, key_sh_q[KEY_W-1-i]};
				if (t >= B_V) begin
					t = t - B_V;
				end
				rem_next = t[IDX_W-1:0];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				busy_q <= 1'b0;
				done_q <= 1'b0;
				cnt_q  <= '0;
			end else begin
				done_q <= 1'b0;
				if (start) begin
					busy_q <= 1'b1;
					cnt_q  <= '0;
				end else if (busy_q) begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'(STEPS - 1)) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			if (start) begin
				key_sh_q <= key;
				rem_q    <= '0;
			end else if (busy_q) begin
				key_sh_q <= key_sh_q << STEP_BITS;
				rem_q    <= rem_next;
			end
		end

		assign done  = done_q;
		assign index = rem_q;
	end

endmodule

[rtl/core/fwsrc_way_logic.sv]
// ----------------------------------------------------------------------------
// fwsrc_way_logic: per-bucket compare and select
// Matches the key over four ways, builds the probe result and the new
// bucket row for write-back.
// ----------------------------------------------------------------------------
module fwsrc_way_logic (
	input  fwsrc_pkg::bucket_t                 row,
	input  fwsrc_pkg::item_t                   item,
	input  logic [fwsrc_pkg::AGE_W-1:0]        cur_age,
	input  logic [fwsrc_pkg::MODE_W-1:0]       mode,
	output fwsrc_pkg::result_t                 result,
	output fwsrc_pkg::update_t                 update
);
	import fwsrc_pkg::*;

	localparam logic [BOUND_W-1:0] BOUND_EXACT = 2'd0;
	localparam logic [BOUND_W-1:0] BOUND_LOWER = 2'd1;
	localparam logic [BOUND_W-1:0] BOUND_UPPER = 2'd2;

	localparam logic [MODE_W-1:0] MODE_DEPTH    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_AGE      = 2'd1;
	localparam logic [MODE_W-1:0] MODE_BALANCED = 2'd2;

	localparam logic signed [16:0] MATE_POS17 = 17'(MATE_LIMIT);
	localparam logic signed [16:0] MATE_NEG17 = 17'(-MATE_LIMIT);
	localparam logic signed [17:0] MATE_POS18 = 18'(MATE_LIMIT);
	localparam logic signed [17:0] MATE_NEG18 = 18'(-MATE_LIMIT);
	localparam logic signed [17:0] SAT_POS    = 18'(SCORE_MAX);
	localparam logic signed [17:0] SAT_NEG    = 18'(-SCORE_MAX);

	function automatic logic [WAY_W-1:0] first_way(input logic [WAYS-1:0] v);
		logic [WAY_W-1:0] r;
		r = '0;
		for (int i = WAYS - 1; i >= 0; i--) begin
			if (v[i]) begin
				r = WAY_W'(i);
			end
		end
		return r;
	endfunction

	function automatic logic [15:0] victim(input entry_t e, input logic [MODE_W-1:0] m);
		logic [7:0]  a;
		logic [8:0]  sum;
		logic [15:0] v;
		a   = 8'hFF - e.age;
		sum = {1'b0, e.depth} + {1'b0, a};
		case (m)
			MODE_DEPTH:    v = {e.depth, a};
			MODE_AGE:      v = {a, e.depth};
			MODE_BALANCED: v = {sum, 7'd0};
			default:       v = '0;
		endcase
		return v;
	endfunction

	logic [WAYS-1:0]   match;
	logic [WAYS-1:0]   empty;
	logic [WAYS-1:0]   shallow;
	logic [WAYS-1:0]   hit_vec;
	logic [15:0]       vscore [WAYS];
	logic [WAY_W-1:0]  hit_way;
	logic [WAY_W-1:0]  best01;
	logic [WAY_W-1:0]  best23;
	logic [WAY_W-1:0]  vic_way;
	logic [WAY_W-1:0]  sel_way;
	entry_t            hent;
	logic signed [16:0] out_s;
	logic signed [16:0] ply17;
	logic signed [17:0] in_s;
	logic signed [17:0] ply18;
	logic               bound_ok;

	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			match[w]   = row[w].key == item.position_key;
			empty[w]   = row[w].key == '0;
			shallow[w] = row[w].depth < item.search_depth;
			vscore[w]  = victim(row[w], mode);
		end
		hit_vec = match & ~empty;
		hit_way = first_way(hit_vec);
		hent    = row[hit_way];

		// undo mate ply adjustment
		ply17 = signed'({9'd0, item.ply_distance});
		out_s = {hent.score[SCORE_W-1], hent.score};
		if (out_s > MATE_POS17) begin
			out_s = out_s - ply17;
		end else if (out_s < MATE_NEG17) begin
			out_s = out_s + ply17;
		end

		// window edges sign-extended, compared signed
		case (hent.bound)
			BOUND_EXACT: bound_ok = 1'b1;
			BOUND_LOWER: bound_ok =
				out_s >= $signed({item.beta_bound[SCORE_W-1], item.beta_bound});
			BOUND_UPPER: bound_ok =
				out_s <= $signed({item.alpha_bound[SCORE_W-1], item.alpha_bound});
			default:     bound_ok = 1'b0;
		endcase

		// fallback victim: least score, ties to lower way
		best01  = (vscore[1] < vscore[0]) ? WAY_W'(1) : WAY_W'(0);
		best23  = (vscore[3] < vscore[2]) ? WAY_W'(3) : WAY_W'(2);
		vic_way = (vscore[best23] < vscore[best01]) ? best23 : best01;

		if (|match) begin
			sel_way = first_way(match);
		end else if (|empty) begin
			sel_way = first_way(empty);
		end else if (|shallow) begin
			sel_way = first_way(shallow);
		end else begin
			sel_way = vic_way;
		end

		// apply mate ply adjustment and clamp
		ply18 = signed'({10'd0, item.ply_distance});
		in_s  = {{2{item.store_score[SCORE_W-1]}}, item.store_score};
		if (in_s > MATE_POS18) begin
			in_s = in_s + ply18;
		end else if (in_s < MATE_NEG18) begin
			in_s = in_s - ply18;
		end
		if (in_s > SAT_POS) begin
			in_s = SAT_POS;
		end
		if (in_s < SAT_NEG) begin
			in_s = SAT_NEG;
		end

		result = '0;
		if (|hit_vec) begin
			result.hit       = 1'b1;
			result.cutoff    = (hent.depth >= item.search_depth) && bound_ok;
			result.hit_move  = hent.move;
			result.hit_score = out_s[SCORE_W-1:0];
			result.hit_depth = hent.depth;
			result.hit_bound = hent.bound;
			result.hit_age   = hent.age;
		end

		update.row   = row;
		update.wr_en = 1'b0;
		case (item.op)
			OP_PROBE: begin
				update.row[hit_way].age = cur_age;
				update.wr_en            = |hit_vec;
			end
			OP_STORE: begin
				update.row[sel_way].key   = item.position_key;
				update.row[sel_way].move  = item.move_word;
				update.row[sel_way].score = in_s[SCORE_W-1:0];
				update.row[sel_way].depth = item.search_depth;
				update.row[sel_way].bound = item.bound_kind;
				update.row[sel_way].age   = cur_age;
				update.wr_en              = 1'b1;
			end
			default: begin
				update.wr_en = 1'b0;
			end
		endcase
	end

endmodule

[rtl/core/four_way_search_result_cache.sv]
// ----------------------------------------------------------------------------
// four_way_search_result_cache: four-way set-associative search result cache
// Power-of-two BUCKETS: a probe/store beat is read, then evaluated and
//   written back; a probe result is registered once the output register is free.
// Other BUCKETS: the bucket remainder is computed before the read.
// New-search and unused ops do not leave idle. Async reset clears control, then a
//   clearing pass writes every bucket row to zero.
// ----------------------------------------------------------------------------
module four_way_search_result_cache #(
	parameter int BUCKETS = 1024
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// slave stream: one command per beat
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// tdata, low bit up: position_key[64], search_depth[8], alpha_bound[16],
	// beta_bound[16], ply_distance[8], move_word[32], store_score[16],
	// bound_kind[2], zero pad[6]
	input  logic [fwsrc_pkg::S_TDATA_W-1:0]      s_tdata,
	// tuser: op[2]
	input  logic [fwsrc_pkg::OP_W-1:0]           s_tuser,
	// master stream: one beat per probe
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// tdata, low bit up: cutoff[1], hit_move[32], hit_score[16],
	// hit_depth[8], hit_bound[2], hit_age[8], zero pad[5]
	output logic [fwsrc_pkg::M_TDATA_W-1:0]      m_tdata,
	// tuser: hit[1]
	output logic [0:0]                           m_tuser,
	// replacement_mode register write
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [fwsrc_pkg::MODE_W-1:0]         cfg_data
);
	import fwsrc_pkg::*;

	localparam int IDX_W = $clog2(BUCKETS);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_HASH  = 2'd2;
	localparam logic [1:0] ST_EVAL  = 2'd3;

	logic [1:0]        state_q;
	logic [IDX_W-1:0]  clr_cnt_q;
	logic [IDX_W-1:0]  idx_q;
	logic [AGE_W-1:0]  age_q;
	logic [MODE_W-1:0] mode_q;
	item_t             item_in;
	item_t             item_q;
	result_t           res_q;
	logic              m_tvalid_q;

	logic              acc;
	logic              need_mem;
	logic              idx_done;
	logic [IDX_W-1:0]  idx_index;
	logic              out_free;
	logic              eval_go;
	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	bucket_t           ram_wdata;
	bucket_t           ram_rdata;
	result_t           result;
	update_t           update;

	// unpack the command beat
	assign item_in.op           = s_tuser;
	assign item_in.position_key = s_tdata[63:0];
	assign item_in.search_depth = s_tdata[71:64];
	assign item_in.alpha_bound  = s_tdata[87:72];
	assign item_in.beta_bound   = s_tdata[103:88];
	assign item_in.ply_distance = s_tdata[111:104];
	assign item_in.move_word    = s_tdata[143:112];
	assign item_in.store_score  = s_tdata[159:144];
	assign item_in.bound_kind   = s_tdata[161:160];

	// one command in flight; the output register decouples the result side
	assign s_tready = state_q == ST_IDLE;
	assign acc      = s_tvalid && s_tready;
	assign need_mem = acc && (item_in.op == OP_PROBE || item_in.op == OP_STORE);

	assign cfg_ready = 1'b1;

	fwsrc_bucket_index #(
		.BUCKETS (BUCKETS)
	) u_index (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (need_mem),
		.key    (item_in.position_key),
		.done   (idx_done),
		.index  (idx_index)
	);

	// bucket read is issued the cycle the index is known
	fwsrc_bucket_ram #(
		.BUCKETS (BUCKETS)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_en   (idx_done),
		.rd_addr (idx_index),
		.rd_data (ram_rdata)
	);

	fwsrc_way_logic u_ways (
		.row     (ram_rdata),
		.item    (item_q),
		.cur_age (age_q),
		.mode    (mode_q),
		.result  (result),
		.update  (update)
	);

	// a probe waits in EVAL until the output register can take its result;
	// read data holds meanwhile since no other read is issued
	assign out_free = !m_tvalid_q || m_tready;
	assign eval_go  = (state_q == ST_EVAL) && (item_q.op != OP_PROBE || out_free);

	always_comb begin
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_cnt_q;
			ram_wdata = '0;
		end else begin
			ram_we    = eval_go && update.wr_en;
			ram_waddr = idx_q;
			ram_wdata = update.row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_cnt_q <= '0;
			age_q     <= '0;
			mode_q    <= '0;
		end else begin
			if (cfg_valid) begin
				mode_q <= cfg_data;
			end
			if (acc && item_in.op == OP_NEW_SEARCH) begin
				age_q <= age_q + AGE_W'(1);
			end
			case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + IDX_W'(1);
					if (clr_cnt_q == IDX_W'(BUCKETS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (need_mem) begin
						state_q <= idx_done ? ST_EVAL : ST_HASH;
					end
				end
				ST_HASH: begin
					if (idx_done) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (eval_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			item_q <= item_in;
		end
		if (idx_done) begin
			idx_q <= idx_index;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (eval_go && item_q.op == OP_PROBE) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (eval_go && item_q.op == OP_PROBE) begin
			res_q <= result;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = res_q.hit;
	assign m_tdata  = {5'd0, res_q.hit_age, res_q.hit_bound, res_q.hit_depth,
		res_q.hit_score, res_q.hit_move, res_q.cutoff};

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: stream-level test of the four-way search result cache
// Drives probe, store, new-search and unused-op beats, keeps a shadow copy of the table,
// the search age and the replacement mode, and checks every probe result beat
// field by field. Directed cases first, then random traffic per mode, with
// random idling on both streams, a long output stall and a drain pause.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import fwsrc_pkg::*;

	localparam int BUCKETS     = 1024;
	localparam int SLOTS       = BUCKETS * WAYS;
	localparam int HOT_ROWS    = 6;       // buckets that random keys crowd into
	localparam int LONG_HOLD   = 300;     // output stall length, in cycles
	localparam int SETTLE      = 16;      // covers a store still in flight
	localparam int CYCLE_LIMIT = 200000;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	localparam logic [BOUND_W-1:0] BOUND_EXACT  = 2'd0;
	localparam logic [BOUND_W-1:0] BOUND_LOWER  = 2'd1;
	localparam logic [BOUND_W-1:0] BOUND_UPPER  = 2'd2;
	localparam logic [BOUND_W-1:0] BOUND_UNUSED = 2'd3;

	localparam logic [MODE_W-1:0] REPL_DEPTH_FIRST = 2'd0;
	localparam logic [MODE_W-1:0] REPL_AGE_FIRST   = 2'd1;
	localparam logic [MODE_W-1:0] REPL_BALANCED    = 2'd2;
	localparam logic [MODE_W-1:0] REPL_UNUSED      = 2'd3;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;   // key, depth, alpha, beta, ply, move, score, bound
	logic [OP_W-1:0]      s_tuser = '0;   // op
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;        // cutoff, move, score, depth, bound, age
	logic [0:0]           m_tuser;        // hit
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [MODE_W-1:0]    cfg_data = '0;

	// shadow of the block state
	entry_t            cache_tbl [SLOTS] = '{default: '0};
	logic [AGE_W-1:0]  search_age = '0;
	logic [MODE_W-1:0] repl_mode = '0;
	bit                age_wrapped = 1'b0;

	result_t           probe_results [$];  // expected probe beats, oldest first
	logic [KEY_W-1:0]  seen_keys [$];      // recently stored keys, for probe hits
	int                hot_rows [HOT_ROWS];

	int  errors = 0;
	int  cycles = 0;
	bit  idle_on = 1'b1;
	int  hold_token = 0;                   // bumped by a test to ask for a long stall
	int  hold_seen = 0;
	int  hold_left = 0;

	four_way_search_result_cache #(
		.BUCKETS(BUCKETS)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Shadow model
	// ------------------------------------------------------------------

	// mate scores carry the distance from the root; clamp to the score range
	function automatic logic [SCORE_W-1:0] score_into_table(logic [SCORE_W-1:0] s,
			logic [PLY_W-1:0] ply);
		int v;
		int p;
		v = $signed(s);
		p = ply;
		if (v > MATE_LIMIT) v = v + p;
		else if (v < -MATE_LIMIT) v = v - p;
		if (v > SCORE_MAX) v = SCORE_MAX;
		if (v < -SCORE_MAX) v = -SCORE_MAX;
		return 16'(v);
	endfunction

	function automatic int score_from_table(logic [SCORE_W-1:0] s, logic [PLY_W-1:0] ply);
		int v;
		int p;
		v = $signed(s);
		p = ply;
		if (v > MATE_LIMIT) return v - p;
		if (v < -MATE_LIMIT) return v + p;
		return v;
	endfunction

	// lower weight = better victim
	function automatic int victim_weight(entry_t e);
		int d;
		int a;
		d = e.depth;
		a = 255 - int'(e.age);
		case (repl_mode)
			REPL_DEPTH_FIRST: return d * 256 + a;
			REPL_AGE_FIRST:   return a * 256 + d;
			REPL_BALANCED:    return d * 128 + a * 128;
			default:          return 0;
		endcase
	endfunction

	// same key, then empty, then shallower, then least weight (lowest way on ties)
	function automatic int choose_victim(int base, logic [KEY_W-1:0] key,
			logic [DEPTH_W-1:0] depth);
		int best_w;
		int best;
		int wt;
		for (int w = 0; w < WAYS; w++)
			if (cache_tbl[base + w].key == key) return w;
		for (int w = 0; w < WAYS; w++)
			if (cache_tbl[base + w].key == '0) return w;
		for (int w = 0; w < WAYS; w++)
			if (depth > cache_tbl[base + w].depth) return w;
		best_w = 0;
		best = victim_weight(cache_tbl[base]);
		for (int w = 1; w < WAYS; w++) begin
			wt = victim_weight(cache_tbl[base + w]);
			if (wt < best) begin
				best = wt;
				best_w = w;
			end
		end
		return best_w;
	endfunction

	// apply one accepted command beat to the shadow table
	task automatic predict_item(input item_t it);
		int      base;
		int      way;
		int      sv;
		bit      found;
		result_t r;
		entry_t  e;
		base = int'(it.position_key % 64'(BUCKETS)) * WAYS;
		case (it.op)
			OP_PROBE: begin
				r = '0;
				found = 1'b0;
				for (int w = 0; w < WAYS; w++) begin
					// key zero marks an empty way and never hits
					if (!found && it.position_key != '0 &&
							cache_tbl[base + w].key == it.position_key) begin
						found = 1'b1;
						e = cache_tbl[base + w];
						sv = score_from_table(e.score, it.ply_distance);
						r.hit = 1'b1;
						r.cutoff = (e.depth >= it.search_depth) &&
							(e.bound == BOUND_EXACT ||
							(e.bound == BOUND_LOWER && sv >= int'($signed(it.beta_bound))) ||
							(e.bound == BOUND_UPPER && sv <= int'($signed(it.alpha_bound))));
						r.hit_move = e.move;
						r.hit_score = 16'(sv);
						r.hit_depth = e.depth;
						r.hit_bound = e.bound;
						r.hit_age = e.age;
						cache_tbl[base + w].age = search_age;
					end
				end
				probe_results.push_back(r);
			end
			OP_STORE: begin
				way = choose_victim(base, it.position_key, it.search_depth);
				e.key = it.position_key;
				e.move = it.move_word;
				e.score = score_into_table(it.store_score, it.ply_distance);
				e.depth = it.search_depth;
				e.bound = it.bound_kind;
				e.age = search_age;
				cache_tbl[base + way] = e;
				if (it.position_key != '0) begin
					seen_keys.push_back(it.position_key);
					if (seen_keys.size() > 48) void'(seen_keys.pop_front());
				end
			end
			OP_NEW_SEARCH: begin
				if (search_age == 8'hFF) age_wrapped = 1'b1;
				search_age = search_age + 1'b1;
			end
			default: ;  // unused op: dropped by the block
		endcase
	endtask

	// ------------------------------------------------------------------
	// Stream drivers
	// ------------------------------------------------------------------

	function automatic logic [S_TDATA_W-1:0] pack_item(item_t it);
		return {6'b0, it.bound_kind, it.store_score, it.move_word, it.ply_distance,
			it.beta_bound, it.alpha_bound, it.search_depth, it.position_key};
	endfunction

	// one command beat; tvalid stays up when the next beat follows at once
	task automatic send_beat(input item_t it);
		int gap;
		gap = idle_on ? $urandom_range(0, 3) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= pack_item(it);
		s_tuser <= it.op;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_item(it);
	endtask

	// stop sending, wait for every probe beat, then let any store finish
	task automatic quiesce();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (probe_results.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_mode(input logic [MODE_W-1:0] mode);
		quiesce();
		cfg_valid <= 1'b1;
		cfg_data <= mode;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		repl_mode = mode;
		cfg_valid <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Output side: random stall after each beat, long stall on request
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (hold_token != hold_seen) begin
			hold_seen = hold_token;
			hold_left = LONG_HOLD;
		end
		if (m_tvalid && m_tready && idle_on && hold_left == 0)
			hold_left = $urandom_range(0, 3);
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left = hold_left - 1;
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic check_field(input string what, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
		end
	endtask

	// result checker: each accepted beat against the oldest pending probe
	always @(posedge clk) begin
		result_t want;
		result_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.hit = m_tuser[0];
			got.cutoff = m_tdata[0];
			got.hit_move = m_tdata[32:1];
			got.hit_score = m_tdata[48:33];
			got.hit_depth = m_tdata[56:49];
			got.hit_bound = m_tdata[58:57];
			got.hit_age = m_tdata[66:59];
			if (probe_results.size() == 0) begin
				errors++;
				$display("%0t: result beat with no probe pending, expected none, got %h",
					$time, got);
			end else begin
				want = probe_results.pop_front();
				check_field("hit", want.hit, got.hit);
				check_field("cutoff", want.cutoff, got.cutoff);
				check_field("hit_move", want.hit_move, got.hit_move);
				check_field("hit_score", want.hit_score, got.hit_score);
				check_field("hit_depth", want.hit_depth, got.hit_depth);
				check_field("hit_bound", want.hit_bound, got.hit_bound);
				check_field("hit_age", want.hit_age, got.hit_age);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	function automatic item_t make_item(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
			int depth, int alpha, int beta, int ply, logic [MOVE_W-1:0] move, int score,
			logic [BOUND_W-1:0] bound);
		item_t it;
		it.op = op;
		it.position_key = key;
		it.search_depth = 8'(depth);
		it.alpha_bound = 16'(alpha);
		it.beta_bound = 16'(beta);
		it.ply_distance = 8'(ply);
		it.move_word = move;
		it.store_score = 16'(score);
		it.bound_kind = bound;
		return it;
	endfunction

	// reuse a stored key, or a fresh one mostly landing in a crowded bucket
	function automatic logic [KEY_W-1:0] draw_key(int reuse_pct);
		logic [KEY_W-1:0] k;
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < reuse_pct && seen_keys.size() > 0)
			return seen_keys[$urandom_range(0, seen_keys.size() - 1)];
		sel = $urandom_range(0, 99);
		if (sel < 3) return '0;
		k = {$urandom, $urandom};
		if (sel >= 8)
			k = k - k % 64'(BUCKETS) + 64'(hot_rows[$urandom_range(0, HOT_ROWS - 1)]);
		return k;
	endfunction

	// half plain scores, half in the mate bands on either side
	function automatic logic [SCORE_W-1:0] draw_score();
		int v;
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 50) begin
			v = int'($urandom_range(0, 65534)) - SCORE_MAX;
		end else begin
			v = int'($urandom_range(MATE_LIMIT - 8, SCORE_MAX));
			if (sel >= 75) v = -v;
		end
		return 16'(v);
	endfunction

	function automatic item_t random_item(int probe_pct, int store_pct, int age_pct);
		item_t it;
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < probe_pct) it.op = OP_PROBE;
		else if (sel < probe_pct + store_pct) it.op = OP_STORE;
		else if (sel < probe_pct + store_pct + age_pct) it.op = OP_NEW_SEARCH;
		else it.op = OP_UNUSED;
		it.position_key = draw_key(it.op == OP_PROBE ? 75 : 35);
		// shallow depths keep buckets full of ties and deeper entries
		it.search_depth = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 24));
		it.alpha_bound = 16'($urandom);
		it.beta_bound = 16'($urandom);
		it.ply_distance = $urandom_range(0, 1) ? 8'($urandom) : 8'($urandom_range(0, 12));
		it.move_word = $urandom;
		it.store_score = draw_score();
		it.bound_kind = ($urandom_range(0, 9) == 0) ? BOUND_UNUSED : 2'($urandom_range(0, 2));
		return it;
	endfunction

	task automatic run_traffic(input int beats, input int probe_pct, input int store_pct,
			input int age_pct);
		hot_rows[0] = 0;
		hot_rows[1] = BUCKETS - 1;
		for (int i = 2; i < HOT_ROWS; i++) hot_rows[i] = $urandom_range(0, BUCKETS - 1);
		for (int i = 0; i < beats; i++) send_beat(random_item(probe_pct, store_pct, age_pct));
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// freshly cleared table: everything misses, unused op is dropped
	task automatic test_empty_table();
		send_beat(make_item(OP_PROBE, '1, 0, 0, 0, 0, '1, 0, BOUND_EXACT));
		send_beat(make_item(OP_PROBE, '0, 255, -32768, 32767, 255, '0, 0, BOUND_EXACT));
		send_beat(make_item(OP_UNUSED, 64'h5, 1, 0, 0, 0, '1, 5, BOUND_EXACT));
	endtask

	// stored fields, mate adjustment both ways, saturation, cutoff rules
	task automatic test_entry_fields();
		// max score plus ply saturates; unused bound never cuts off
		send_beat(make_item(OP_STORE, 64'hFFFF_FFFF_FFFF_FC05, 255, 0, 0, 255, '1,
			SCORE_MAX, BOUND_UNUSED));
		send_beat(make_item(OP_PROBE, 64'hFFFF_FFFF_FFFF_FC05, 255, 32767, -32768, 0, '0,
			0, BOUND_EXACT));
		// negative mate, lower bound at the beta floor
		send_beat(make_item(OP_STORE, 64'h8000_0000_0000_0005, 0, 0, 0, 255, '0,
			-SCORE_MAX, BOUND_LOWER));
		send_beat(make_item(OP_PROBE, 64'h8000_0000_0000_0005, 0, 0, -32768, 255, '0,
			0, BOUND_EXACT));
		// just inside the mate band, upper bound right at alpha
		send_beat(make_item(OP_STORE, 64'h0123_4567_89AB_C405, 10, 0, 0, 10, 32'h1234_5678,
			MATE_LIMIT + 1, BOUND_UPPER));
		send_beat(make_item(OP_PROBE, 64'h0123_4567_89AB_C405, 10, MATE_LIMIT + 1, 0, 10,
			'0, 0, BOUND_EXACT));
		// edge of the band is not adjusted; too shallow for a cutoff
		send_beat(make_item(OP_STORE, 64'h0000_0000_0000_0405, 0, 0, 0, 200, 32'h0000_0001,
			MATE_LIMIT, BOUND_EXACT));
		send_beat(make_item(OP_PROBE, 64'h0000_0000_0000_0405, 1, 0, 0, 200, '0, 0,
			BOUND_EXACT));
	endtask

	// zero key: the store lands but the way stays empty, probe never hits
	task automatic test_key_zero();
		send_beat(make_item(OP_STORE, '0, 3, 0, 0, 0, 32'hCAFE_F00D, 100, BOUND_EXACT));
		send_beat(make_item(OP_PROBE, '0, 0, 0, 0, 0, '0, 0, BOUND_EXACT));
	endtask

	// probe reports the old age and refreshes it to the current one
	task automatic test_age_refresh();
		send_beat(make_item(OP_NEW_SEARCH, '0, 0, 0, 0, 0, '0, 0, BOUND_EXACT));
		send_beat(make_item(OP_PROBE, 64'hFFFF_FFFF_FFFF_FC05, 0, 0, 0, 0, '0, 0,
			BOUND_EXACT));
		send_beat(make_item(OP_PROBE, 64'hFFFF_FFFF_FFFF_FC05, 0, 0, 0, 0, '0, 0,
			BOUND_EXACT));
	endtask

	// fill one bucket, then evict by depth and by the depth-first weight
	task automatic test_bucket_replacement();
		for (int i = 0; i < WAYS; i++)
			send_beat(make_item(OP_STORE, 64'((i + 1) * BUCKETS + 7), 5, 0, 0, 0, 32'(i),
				i, BOUND_EXACT));
		send_beat(make_item(OP_NEW_SEARCH, '0, 0, 0, 0, 0, '0, 0, BOUND_EXACT));
		send_beat(make_item(OP_STORE, 64'(9 * BUCKETS + 7), 9, 0, 0, 0, 32'h9, 9,
			BOUND_LOWER));
		send_beat(make_item(OP_STORE, 64'(10 * BUCKETS + 7), 2, 0, 0, 0, 32'hA, 10,
			BOUND_UPPER));
		send_beat(make_item(OP_PROBE, 64'(1 * BUCKETS + 7), 0, 0, 0, 0, '0, 0, BOUND_EXACT));
		send_beat(make_item(OP_PROBE, 64'(2 * BUCKETS + 7), 0, 0, 0, 0, '0, 0, BOUND_EXACT));
		send_beat(make_item(OP_PROBE, 64'(10 * BUCKETS + 7), 0, 0, 0, 0, '0, 0, BOUND_EXACT));
	endtask

	task automatic test_age_first_mode();
		write_mode(REPL_AGE_FIRST);
		run_traffic(220, 40, 45, 12);
	endtask

	// output held off while commands keep coming: block fills and stalls its input
	task automatic test_balanced_mode_backpressure();
		write_mode(REPL_BALANCED);
		hold_token <= hold_token + 1;
		run_traffic(220, 45, 40, 12);
	endtask

	// unused mode makes way 0 the fallback victim; sender drains halfway through
	task automatic test_unused_mode_pause();
		write_mode(REPL_UNUSED);
		run_traffic(70, 40, 45, 12);
		quiesce();
		run_traffic(70, 40, 45, 12);
	endtask

	// back-to-back beats on both streams
	task automatic test_depth_first_steady();
		write_mode(REPL_DEPTH_FIRST);
		idle_on = 1'b0;
		run_traffic(220, 40, 45, 12);
		idle_on = 1'b1;
	endtask

	// heavy new-search traffic until the age counter has wrapped
	task automatic test_age_wrap();
		write_mode(REPL_BALANCED);
		run_traffic(300, 25, 13, 60);
		while (!age_wrapped) run_traffic(20, 25, 13, 60);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		write_mode(REPL_DEPTH_FIRST);
		test_empty_table();
		test_entry_fields();
		test_key_zero();
		test_age_refresh();
		test_bucket_replacement();
		test_age_first_mode();
		test_balanced_mode_backpressure();
		test_unused_mode_pause();
		test_depth_first_steady();
		test_age_wrap();
		quiesce();
		if (errors == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

endmodule

[files.f]
rtl/core/fwsrc_pkg.sv
rtl/core/fwsrc_bucket_ram.sv
rtl/core/fwsrc_bucket_index.sv
rtl/core/fwsrc_way_logic.sv
rtl/core/four_way_search_result_cache.sv
bench/tb_top.sv
